@@ src/fcdma_pkg.sv @@
// ----------------------------------------------------------------------------
// fcdma_pkg
// Shared types, codes and helpers for the four-channel DMA register block.
// ----------------------------------------------------------------------------
package fcdma_pkg;

  localparam int SHORT_COUNT_BITS_DEF = 14;
  localparam int LONG_COUNT_BITS_DEF  = 16;

  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_WRITE = 2'd2;
  localparam logic [1:0] CMD_BAD   = 2'd3;

  localparam logic [1:0] SIZE_BYTE = 2'd0;
  localparam logic [1:0] SIZE_HALF = 2'd1;
  localparam logic [1:0] SIZE_WORD = 2'd2;
  localparam logic [1:0] SIZE_BAD  = 2'd3;

  localparam logic [1:0] KIND_ACK  = 2'd0;
  localparam logic [1:0] KIND_READ = 2'd1;
  localparam logic [1:0] KIND_COPY = 2'd2;

  localparam logic [1:0] ERR_NONE  = 2'd0;
  localparam logic [1:0] ERR_SPEC0 = 2'd1;
  localparam logic [1:0] ERR_SRC3  = 2'd2;

  localparam logic [7:0] REG_LOW  = 8'hB0;
  localparam logic [7:0] REG_HIGH = 8'hDF;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [1:0]  size;
    logic [7:0]  off;
    logic [31:0] data;
  } fcdma_in_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] read_data;
    logic [31:0] copy_source;
    logic [31:0] copy_dest;
    logic        copy_wide;
    logic        copy_last;
    logic [1:0]  error_code;
    logic        busy_refused;
  } fcdma_out_t;

  // One channel's register row.
  typedef struct packed {
    logic [31:0] src;
    logic [31:0] dst;
    logic [15:0] cnt;
    logic [15:0] ctl;
  } fcdma_row_t;

  function automatic logic [31:0] step_of(input logic [1:0] mode, input logic wide);
    logic [31:0] sz;
    sz = wide ? 32'd4 : 32'd2;
    case (mode)
      2'd1:    step_of = 32'd0 - sz;
      2'd2:    step_of = 32'd0;
      default: step_of = sz;
    endcase
  endfunction

endpackage

@@ src/fcdma_if.sv @@
// ----------------------------------------------------------------------------
// fcdma_if
// Valid/ready channel carrying one payload item.
// ----------------------------------------------------------------------------
interface fcdma_if #(parameter int W = 1);
  logic         valid;
  logic         ready;
  logic [W-1:0] payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

@@ src/four_channel_dma_controller_unit.sv @@
// ----------------------------------------------------------------------------
// four_channel_dma_controller_unit
// Four-channel DMA register block with immediate-start unit copy sequencer.
// ----------------------------------------------------------------------------
//  channel | dir | payload
//  in_     | in  | command, access_size, reg_offset, write_data
//  out_    | out | kind, read_data, copy_*, error_code, busy_refused
//
// One item per cycle when not stalled, two-stage pipeline: stage 0 issues
// the channel row read, stage 1 merges, decodes and writes the row back
// (write forwarded to a following read of the same row). The result is
// registered in the output register after stage 1 and offered from there.
// Reset (rst_n, synchronous) clears busy, valid bits and pipeline valids.
// The pipeline stalls as a whole while a held result is not taken.
module four_channel_dma_controller_unit
  import fcdma_pkg::*;
#(
  parameter int SHORT_COUNT_BITS = SHORT_COUNT_BITS_DEF,
  parameter int LONG_COUNT_BITS  = LONG_COUNT_BITS_DEF
) (
  input logic clk,
  input logic rst_n,
  fcdma_if.sink   in_ch,
  fcdma_if.source out_ch
);
  fcdma_in_t  in_item;
  logic       adv;
  logic       s1_v_r;
  fcdma_in_t  s1_r;
  logic [1:0] s1_ch_r;
  logic       o_v_r;
  fcdma_out_t o_r;
  fcdma_out_t res;
  fcdma_row_t rd_row, wr_row;
  logic       wr_en, busy;
  logic [1:0] wr_addr;
  logic [1:0] ch0;
  logic [3:0] nb0;
  logic [7:0] off0, rel0;

  assign in_item = in_ch.payload;
  // Stage advance: output register free or being drained.
  assign adv = !o_v_r || out_ch.ready;
  assign in_ch.ready = adv;

  // Channel of a register access, from the aligned offset.
  always_comb begin
    nb0  = 4'd1 << in_item.size;
    off0 = in_item.off & ~(8'(nb0) - 8'd1);
    rel0 = off0 - REG_LOW;
    ch0  = (rel0 < 8'd12) ? 2'd0 : (rel0 < 8'd24) ? 2'd1 :
           (rel0 < 8'd36) ? 2'd2 : 2'd3;
  end

  // A tick while a start sits in stage 1 must still read the active row;
  // stage 1's channel for ticks comes from the row register chosen here.
  logic [1:0] act_r;
  logic [1:0] rd_ch;
  assign rd_ch = (in_item.cmd == CMD_TICK) ?
                 ((s1_v_r && wr_en && !busy) ? wr_addr : act_r) : ch0;

  always_ff @(posedge clk) begin
    if (!rst_n) act_r <= '0;
    else if (s1_v_r && adv && !busy && s1_r.cmd == CMD_WRITE && wr_en) act_r <= wr_addr;
  end

  fcdma_regmem u_mem (
    .clk, .rst_n,
    .rd_en(adv), .rd_addr(rd_ch), .rd_row,
    .wr_en(wr_en && adv), .wr_addr, .wr_row
  );

  fcdma_core #(
    .SHORT_COUNT_BITS(SHORT_COUNT_BITS), .LONG_COUNT_BITS(LONG_COUNT_BITS)
  ) u_core (
    .clk, .rst_n, .adv,
    .s1_v(s1_v_r && adv), .s1_in(s1_r), .s1_ch(s1_ch_r), .rd_row,
    .wr_en, .wr_addr, .wr_row, .res, .busy
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      o_v_r  <= 1'b0;
    end else if (adv) begin
      s1_v_r <= in_ch.valid;
      o_v_r  <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_r    <= in_item;
      s1_ch_r <= rd_ch;
      o_r     <= res;
    end
  end

  assign out_ch.valid   = o_v_r;
  assign out_ch.payload = o_r;

`ifndef SYNTHESIS
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    o_v_r && !out_ch.ready |=> $stable(o_r)) else $error("result changed while held");
  a_kind: assert property (@(posedge clk) disable iff (!rst_n)
    o_v_r |-> o_r.kind != 2'd3) else $error("bad result kind");
  a_ref: assert property (@(posedge clk) disable iff (!rst_n)
    o_v_r && o_r.busy_refused |-> o_r.kind == KIND_ACK) else $error("refusal with data");
`endif
endmodule

@@ src/fcdma_regmem.sv @@
// ----------------------------------------------------------------------------
// fcdma_regmem
// Channel register memory: one row per channel, sync read, one write port.
// Valid bits stand in for the reset clear.
// ----------------------------------------------------------------------------
module fcdma_regmem
  import fcdma_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       rd_en,
  input  logic [1:0] rd_addr,
  output fcdma_row_t rd_row,
  input  logic       wr_en,
  input  logic [1:0] wr_addr,
  input  fcdma_row_t wr_row
);
  fcdma_row_t mem [4];
  fcdma_row_t q_r;
  logic [3:0] vld_r;
  logic       qv_r;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_row;
    if (rd_en) q_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      qv_r  <= 1'b0;
    end else begin
      if (wr_en) vld_r[wr_addr] <= 1'b1;
      if (rd_en) qv_r <= vld_r[rd_addr];
    end
  end

  assign rd_row = qv_r ? q_r : '0;
endmodule

@@ src/fcdma_core.sv @@
// ----------------------------------------------------------------------------
// fcdma_core
// Access decode, row merge, control decode and transfer sequencing.
// ----------------------------------------------------------------------------
module fcdma_core
  import fcdma_pkg::*;
#(
  parameter int SHORT_COUNT_BITS = SHORT_COUNT_BITS_DEF,
  parameter int LONG_COUNT_BITS  = LONG_COUNT_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       adv,
  input  logic       s1_v,
  input  fcdma_in_t  s1_in,
  input  logic [1:0] s1_ch,
  input  fcdma_row_t rd_row,
  output logic       wr_en,
  output logic [1:0] wr_addr,
  output fcdma_row_t wr_row,
  output fcdma_out_t res,
  output logic       busy
);
  localparam logic [15:0] SMASK = 16'((17'd1 << SHORT_COUNT_BITS) - 17'd1);
  localparam logic [15:0] LMASK = 16'((17'd1 << LONG_COUNT_BITS) - 17'd1);

  logic [31:0] cur_src_r, cur_dst_r;
  logic [15:0] left_r;
  logic        busy_r;

  // Forwarding of the row written by the previous stage-1 item; held on stall.
  logic       fw_v_r;
  logic [1:0] fw_a_r;
  fcdma_row_t fw_r;
  fcdma_row_t row;

  assign row  = (fw_v_r && fw_a_r == s1_ch) ? fw_r : rd_row;
  assign busy = busy_r;

  logic [3:0]  nb;
  logic [7:0]  off;
  logic [7:0]  rel;
  logic [3:0]  lane;
  logic [3:0]  lb;
  logic        inr;
  logic [15:0] mask;
  logic [15:0] nxt;
  fcdma_row_t  m;
  logic        touched;
  logic [31:0] rdv;
  logic [1:0]  tim;
  logic        start;

  always_comb begin
    nb   = 4'd1 << s1_in.size;
    off  = s1_in.off & ~(8'(nb) - 8'd1);
    inr  = off >= REG_LOW && off <= REG_HIGH;
    rel  = off - REG_LOW;
    lane = 4'(rel - 8'(s1_ch) * 8'd12);
    mask = (s1_ch == 2'd3) ? LMASK : SMASK;
    nxt  = (left_r - 16'd1) & mask;
    res  = '0;
    m    = row;
    touched = 1'b0;
    rdv  = '0;
    start = 1'b0;
    lb   = 4'd0;
    wr_en = 1'b0;
    wr_addr = s1_ch;
    for (int b = 0; b < 4; b++) begin
      lb = 4'(lane + 4'(b));
      if (b < int'(nb)) begin
        case (lb) inside
          [4'd0:4'd3]: m.src[8*lb[1:0] +: 8] = s1_in.data[8*b +: 8];
          [4'd4:4'd7]: m.dst[8*lb[1:0] +: 8] = s1_in.data[8*b +: 8];
          4'd8:  m.cnt[7:0]  = s1_in.data[8*b +: 8];
          4'd9:  m.cnt[15:8] = s1_in.data[8*b +: 8];
          4'd10: begin
            m.ctl[7:0] = s1_in.data[8*b +: 8];
            rdv[8*b +: 8] = row.ctl[7:0];
            touched = 1'b1;
          end
          4'd11: begin
            m.ctl[15:8] = s1_in.data[8*b +: 8];
            rdv[8*b +: 8] = row.ctl[15:8];
            touched = 1'b1;
          end
          default: ;
        endcase
      end
    end
    tim = m.ctl[13:12];
    if (s1_v) begin
      if (s1_in.cmd == CMD_TICK) begin
        if (busy_r) begin
          res.kind        = KIND_COPY;
          res.copy_source = cur_src_r;
          res.copy_dest   = cur_dst_r;
          res.copy_wide   = row.ctl[10];
          res.copy_last   = (nxt == 16'd0);
          if (nxt == 16'd0) begin
            wr_en = 1'b1;
            m = row;
            m.ctl[15] = 1'b0;
          end
        end
      end else if (s1_in.cmd != CMD_BAD && s1_in.size != SIZE_BAD) begin
        if (busy_r) res.busy_refused = 1'b1;
        else if (s1_in.cmd == CMD_READ) begin
          res.kind = KIND_READ;
          if (inr) res.read_data = rdv;
        end else if (inr) begin
          wr_en = 1'b1;
          if (touched && m.ctl[15]) begin
            if (tim == 2'd3 && s1_ch == 2'd0) res.error_code = ERR_SPEC0;
            else if (m.ctl[8:7] == 2'd3) res.error_code = ERR_SRC3;
            else if (tim == 2'd0) start = 1'b1;
          end
        end
      end
    end
    wr_row = m;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fw_v_r <= 1'b0;
      left_r <= '0;
      cur_src_r <= '0;
      cur_dst_r <= '0;
    end else begin
      if (adv) fw_v_r <= wr_en;
      if (s1_v && s1_in.cmd == CMD_TICK && busy_r) begin
        cur_src_r <= cur_src_r + step_of(row.ctl[8:7], row.ctl[10]);
        cur_dst_r <= cur_dst_r + step_of(row.ctl[6:5], row.ctl[10]);
        left_r    <= nxt;
        if (nxt == 16'd0) busy_r <= 1'b0;
      end
      if (start) begin
        busy_r    <= 1'b1;
        left_r    <= m.cnt & mask;
        cur_src_r <= m.src;
        cur_dst_r <= m.dst;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      fw_a_r <= wr_addr;
      fw_r   <= wr_row;
    end
  end
endmodule
